/* hw/rtl/qpm_pkg.sv */
`default_nettype none
package qpm_pkg;
  localparam int COORD_BITS_DEF = 20;
  localparam int THICK_BITS     = 10;
  localparam int AREA_BITS      = 42;
  localparam int PERIM_BITS     = 23;
  localparam int HALF_BITS      = 21;
  localparam int VOL_BITS       = 52;
  localparam int SURF_BITS      = 43;

  // One finished set of measures.
  typedef struct packed {
    logic [AREA_BITS-1:0]  area_mm2;
    logic [PERIM_BITS-1:0] perimeter_mm;
    logic [HALF_BITS-1:0]  width_mm;
    logic [HALF_BITS-1:0]  height_mm;
    logic [VOL_BITS-1:0]   volume_mm3;
    logic [SURF_BITS-1:0]  surface_mm2;
  } res_t;
endpackage
`default_nettype wire

/* hw/rtl/qpm_coord_if.sv */
`default_nettype none
interface qpm_coord_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z;
  logic signed [COORD_BITS-1:0] p3_x, p3_y, p3_z;
  logic signed [COORD_BITS-1:0] p4_x, p4_y, p4_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qpm_res_if.sv */
`default_nettype none
interface qpm_res_if
  import qpm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [AREA_BITS-1:0]  area_mm2;
  logic [PERIM_BITS-1:0] perimeter_mm;
  logic [HALF_BITS-1:0]  width_mm;
  logic [HALF_BITS-1:0]  height_mm;
  logic [VOL_BITS-1:0]   volume_mm3;
  logic [SURF_BITS-1:0]  surface_mm2;

  modport source (output valid, area_mm2, perimeter_mm, width_mm, height_mm,
                  volume_mm3, surface_mm2, input ready);
  modport sink (input valid, area_mm2, perimeter_mm, width_mm, height_mm,
                volume_mm3, surface_mm2, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qpm_cfg_if.sv */
`default_nettype none
interface qpm_cfg_if
  import qpm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [THICK_BITS-1:0] thickness_mm;

  modport source (output valid, thickness_mm, input ready);
  modport sink (input valid, thickness_mm, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qpm_cross.sv */
`default_nettype none
module qpm_cross
  import qpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * COORD_BITS + 2,
  localparam int MW = 2 * COORD_BITS + 1,
  localparam int EW = 2 * COORD_BITS + 2
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire                         in_valid,
  input  wire signed [COORD_BITS-1:0] pt [4][3],
  output logic                        out_valid,
  output logic [MW-1:0]               cmag [2][3],
  output logic [EW-1:0]               esum [4]
);
  // difference vectors: 0 v12, 1 v14, 2 v32, 3 v34, 4 v23
  logic signed [DW-1:0]   d [5][3];
  logic signed [PW-1:0]   pa [2][3];
  logic signed [PW-1:0]   pb [2][3];
  logic [2*COORD_BITS-1:0] esq [4][3];
  logic                   v1, v2;
  logic [COORD_BITS-1:0]  emag [4][3];
  logic signed [PW:0]     cdif [2][3];

  function automatic logic signed [DW-1:0] sub(input logic signed [COORD_BITS-1:0] a,
                                              input logic signed [COORD_BITS-1:0] b);
    sub = DW'(a) - DW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // edge components: v12, v23, v34, v14
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      emag[0][k] = d[0][k][DW-1] ? COORD_BITS'(-d[0][k]) : COORD_BITS'(d[0][k]);
      emag[1][k] = d[4][k][DW-1] ? COORD_BITS'(-d[4][k]) : COORD_BITS'(d[4][k]);
      emag[2][k] = d[3][k][DW-1] ? COORD_BITS'(-d[3][k]) : COORD_BITS'(d[3][k]);
      emag[3][k] = d[1][k][DW-1] ? COORD_BITS'(-d[1][k]) : COORD_BITS'(d[1][k]);
    end
    for (int t = 0; t < 2; t++)
      for (int k = 0; k < 3; k++)
        cdif[t][k] = (PW+1)'(pa[t][k]) - (PW+1)'(pb[t][k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d[0][k] <= sub(pt[1][k], pt[0][k]);
        d[1][k] <= sub(pt[3][k], pt[0][k]);
        d[2][k] <= sub(pt[1][k], pt[2][k]);
        d[3][k] <= sub(pt[3][k], pt[2][k]);
        d[4][k] <= sub(pt[2][k], pt[1][k]);
      end
      // v12 x v14 and v34 x v32
      pa[0][0] <= PW'(d[0][1]) * PW'(d[1][2]);
      pb[0][0] <= PW'(d[0][2]) * PW'(d[1][1]);
      pa[0][1] <= PW'(d[0][2]) * PW'(d[1][0]);
      pb[0][1] <= PW'(d[0][0]) * PW'(d[1][2]);
      pa[0][2] <= PW'(d[0][0]) * PW'(d[1][1]);
      pb[0][2] <= PW'(d[0][1]) * PW'(d[1][0]);
      pa[1][0] <= PW'(d[3][1]) * PW'(d[2][2]);
      pb[1][0] <= PW'(d[3][2]) * PW'(d[2][1]);
      pa[1][1] <= PW'(d[3][2]) * PW'(d[2][0]);
      pb[1][1] <= PW'(d[3][0]) * PW'(d[2][2]);
      pa[1][2] <= PW'(d[3][0]) * PW'(d[2][1]);
      pb[1][2] <= PW'(d[3][1]) * PW'(d[2][0]);
      for (int e = 0; e < 4; e++)
        for (int k = 0; k < 3; k++)
          esq[e][k] <= (2*COORD_BITS)'(emag[e][k]) * (2*COORD_BITS)'(emag[e][k]);
      for (int t = 0; t < 2; t++)
        for (int k = 0; k < 3; k++)
          cmag[t][k] <= cdif[t][k][PW] ? MW'(-cdif[t][k]) : MW'(cdif[t][k]);
      for (int e = 0; e < 4; e++)
        esum[e] <= EW'(esq[e][0]) + EW'(esq[e][1]) + EW'(esq[e][2]);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/qpm_sqsum.sv */
`default_nettype none
module qpm_sqsum
  import qpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int MW = 2 * COORD_BITS + 1,
  localparam int EW = 2 * COORD_BITS + 2,
  localparam int SW = 4 * COORD_BITS + 4,
  localparam int LB = (MW + 1) / 2,
  localparam int HB = MW - LB
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  wire            in_valid,
  input  wire [MW-1:0]   cmag [2][3],
  input  wire [EW-1:0]   esum [4],
  output logic           out_valid,
  output logic [SW-1:0]  rad [6]
);
  logic [2*HB-1:0]    hh [2][3];
  logic [HB+LB-1:0]   hl [2][3];
  logic [2*LB-1:0]    ll [2][3];
  logic [2*MW-1:0]    sq [2][3];
  logic [EW-1:0]      e1 [4];
  logic [EW-1:0]      e2 [4];
  logic               v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // split each square into halves to keep the multipliers narrow
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 2; t++)
        for (int k = 0; k < 3; k++) begin
          hh[t][k] <= (2*HB)'(cmag[t][k][MW-1:LB]) * (2*HB)'(cmag[t][k][MW-1:LB]);
          hl[t][k] <= (HB+LB)'(cmag[t][k][MW-1:LB]) * (HB+LB)'(cmag[t][k][LB-1:0]);
          ll[t][k] <= (2*LB)'(cmag[t][k][LB-1:0]) * (2*LB)'(cmag[t][k][LB-1:0]);
          sq[t][k] <= ((2*MW)'(hh[t][k]) << (2*LB)) + ((2*MW)'(hl[t][k]) << (LB+1))
                      + (2*MW)'(ll[t][k]);
        end
      for (int t = 0; t < 2; t++)
        rad[t] <= SW'(sq[t][0]) + SW'(sq[t][1]) + SW'(sq[t][2]);
      for (int e = 0; e < 4; e++) begin
        e1[e] <= esum[e];
        e2[e] <= e1[e];
        rad[e+2] <= SW'(e2[e]);
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/qpm_isqrt.sv */
`default_nettype none
module qpm_isqrt #(
  parameter int N = 84,
  localparam int R = N / 2
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           en,
  input  wire           in_valid,
  input  wire [N-1:0]   rad,
  output logic          out_valid,
  output logic [R-1:0]  root
);
  // one root bit per stage, restoring
  logic [N-1:0] rq  [R+1];
  logic [R:0]   rem [R+1];
  logic [R-1:0] rt  [R+1];
  logic         vq  [R+1];

  assign rq[0]  = rad;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign vq[0]  = in_valid;

  for (genvar s = 0; s < R; s++) begin : g_stage
    logic [R+2:0] cur, trial;
    logic         take;
    assign cur   = {rem[s], rq[s][N-1:N-2]};
    assign trial = (R+3)'({rt[s], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[s+1] <= 1'b0;
      end else if (en) begin
        vq[s+1] <= vq[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq[s+1]  <= rq[s] << 2;
        rem[s+1] <= take ? (R+1)'(cur - trial) : (R+1)'(cur);
        rt[s+1]  <= {rt[s][R-2:0], take};
      end
    end
  end

  assign out_valid = vq[R];
  assign root      = rt[R];
endmodule
`default_nettype wire

/* hw/rtl/qpm_post.sv */
`default_nettype none
module qpm_post
  import qpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int R  = 2 * COORD_BITS + 2,
  localparam int LW = COORD_BITS + 1,
  localparam int PW = COORD_BITS + 3,
  localparam int VW = R + THICK_BITS,
  localparam int TW = PW + THICK_BITS,
  localparam int FW = ((R + 1 > TW) ? R + 1 : TW) + 1
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire                   in_valid,
  input  wire [R-1:0]           root [6],
  input  wire [THICK_BITS-1:0]  thick,
  output logic                  out_valid,
  output res_t                  res
);
  localparam int AE = ((R > AREA_BITS) ? R : AREA_BITS) + 1;
  localparam int PE = ((PW > PERIM_BITS) ? PW : PERIM_BITS) + 1;
  localparam int HE = ((LW > HALF_BITS) ? LW : HALF_BITS) + 1;
  localparam int VE = ((VW > VOL_BITS) ? VW : VOL_BITS) + 1;
  localparam int SE = ((FW > SURF_BITS) ? FW : SURF_BITS) + 1;

  logic [R-1:0]  area1, area2;
  logic [PW-1:0] per1, per2;
  logic [LW-1:0] wid1, wid2, hgt1, hgt2;
  logic [VW-1:0] vol2;
  logic [TW-1:0] pt2;
  logic          v1, v2;
  logic [R:0]    asum;
  logic [LW:0]   wsum, hsum;
  logic [FW-1:0] surf;
  logic [AE-1:0] ax;
  logic [PE-1:0] px;
  logic [HE-1:0] wx, hx;
  logic [VE-1:0] vx;
  logic [SE-1:0] sx;

  always_comb begin
    asum = (R+1)'(root[0]) + (R+1)'(root[1]);
    wsum = (LW+1)'(root[2][LW-1:0]) + (LW+1)'(root[4][LW-1:0]);
    hsum = (LW+1)'(root[3][LW-1:0]) + (LW+1)'(root[5][LW-1:0]);
    surf = (FW'(area2) << 1) + FW'(pt2);
    ax = AE'(area2);
    px = PE'(per2);
    wx = HE'(wid2);
    hx = HE'(hgt2);
    vx = VE'(vol2);
    sx = SE'(surf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area1 <= asum[R:1];
      per1  <= PW'(root[2][LW-1:0]) + PW'(root[3][LW-1:0])
               + PW'(root[4][LW-1:0]) + PW'(root[5][LW-1:0]);
      wid1  <= wsum[LW:1];
      hgt1  <= hsum[LW:1];

      area2 <= area1;
      per2  <= per1;
      wid2  <= wid1;
      hgt2  <= hgt1;
      vol2  <= VW'(area1) * VW'(thick);
      pt2   <= TW'(per1) * TW'(thick);

      // clamp each field at its all-ones value
      res.area_mm2 <= (ax > AE'({AREA_BITS{1'b1}})) ? '1 : ax[AREA_BITS-1:0];
      res.perimeter_mm <= (px > PE'({PERIM_BITS{1'b1}})) ? '1 : px[PERIM_BITS-1:0];
      res.width_mm <= (wx > HE'({HALF_BITS{1'b1}})) ? '1 : wx[HALF_BITS-1:0];
      res.height_mm <= (hx > HE'({HALF_BITS{1'b1}})) ? '1 : hx[HALF_BITS-1:0];
      res.volume_mm3 <= (vx > VE'({VOL_BITS{1'b1}})) ? '1 : vx[VOL_BITS-1:0];
      res.surface_mm2 <= (sx > SE'({SURF_BITS{1'b1}})) ? '1 : sx[SURF_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/quad_panel_measures.sv */
`default_nettype none
// Quadrilateral panel measures. Each coord transaction carries the four
// corners of one panel; one res transaction returns its area, perimeter,
// mean width and height, volume and surface area, in input order. A new
// panel may enter on every clock cycle while coord.ready is high. From the
// coord transaction to the first edge at which the result can be taken, a
// panel passes six register stages of vector, product and squaring logic,
// 2*COORD_BITS+2 square-root stages that each resolve one root bit, three
// stages of final arithmetic and one in the output queue. The whole
// pipeline advances together; a two-entry output queue absorbs
// back-pressure, so coord.ready drops only once both entries hold results
// that the consumer has not yet taken. The thickness register is always
// ready, resets to zero and must be written only while the block is idle.
module quad_panel_measures
  import qpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  qpm_coord_if.sink    coord,
  qpm_cfg_if.sink      cfg,
  qpm_res_if.source    res
);
  localparam int MW = 2 * COORD_BITS + 1;
  localparam int EW = 2 * COORD_BITS + 2;
  localparam int SW = 4 * COORD_BITS + 4;
  localparam int R  = SW / 2;

  logic [THICK_BITS-1:0]   thick;
  logic                    en;
  logic signed [COORD_BITS-1:0] pt [4][3];
  logic                    cr_valid, sq_valid, rt_valid, post_valid;
  logic [MW-1:0]           cmag [2][3];
  logic [EW-1:0]           esum [4];
  logic [SW-1:0]           rad [6];
  logic [R-1:0]            root [6];
  res_t                    post_res;
  res_t                    buf0, buf1;
  logic [1:0]              cnt;
  logic                    push, pop;

  // configuration: always take the write
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thick <= '0;
    end else if (cfg.valid) begin
      thick <= cfg.thickness_mm;
    end
  end

  // advance the whole pipeline while the output queue has a free entry
  assign en          = (cnt != 2'd2);
  assign coord.ready = en;

  assign pt[0][0] = coord.p1_x;
  assign pt[0][1] = coord.p1_y;
  assign pt[0][2] = coord.p1_z;
  assign pt[1][0] = coord.p2_x;
  assign pt[1][1] = coord.p2_y;
  assign pt[1][2] = coord.p2_z;
  assign pt[2][0] = coord.p3_x;
  assign pt[2][1] = coord.p3_y;
  assign pt[2][2] = coord.p3_z;
  assign pt[3][0] = coord.p4_x;
  assign pt[3][1] = coord.p4_y;
  assign pt[3][2] = coord.p4_z;

  qpm_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coord.valid),
    .pt        (pt),
    .out_valid (cr_valid),
    .cmag      (cmag),
    .esum      (esum)
  );

  qpm_sqsum #(.COORD_BITS(COORD_BITS)) u_sqsum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cr_valid),
    .cmag      (cmag),
    .esum      (esum),
    .out_valid (sq_valid),
    .rad       (rad)
  );

  // six roots: two triangle cross norms, then edges 1-2, 2-3, 3-4, 4-1
  qpm_isqrt #(.N(SW)) u_sqrt0 (
    .clk (clk), .rst (rst), .en (en), .in_valid (sq_valid),
    .rad (rad[0]), .out_valid (rt_valid), .root (root[0])
  );

  for (genvar i = 1; i < 6; i++) begin : g_sqrt
    qpm_isqrt #(.N(SW)) u_sqrt (
      .clk (clk), .rst (rst), .en (en), .in_valid (sq_valid),
      .rad (rad[i]), .out_valid (), .root (root[i])
    );
  end

  qpm_post #(.COORD_BITS(COORD_BITS)) u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_valid),
    .root      (root),
    .thick     (thick),
    .out_valid (post_valid),
    .res       (post_res)
  );

  // two-entry output queue; buf0 is the head
  assign push = en && post_valid;
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : post_res;
      if (cnt == 2'd2 && push) begin
        buf1 <= post_res;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= post_res;
      end else begin
        buf1 <= post_res;
      end
    end
  end

  assign res.valid        = (cnt != 2'd0);
  assign res.area_mm2     = buf0.area_mm2;
  assign res.perimeter_mm = buf0.perimeter_mm;
  assign res.width_mm     = buf0.width_mm;
  assign res.height_mm    = buf0.height_mm;
  assign res.volume_mm3   = buf0.volume_mm3;
  assign res.surface_mm2  = buf0.surface_mm2;
endmodule
`default_nettype wire
